// ===== hw/rtl/sfsc_pkg.sv =====
// ============================================================================
// sfsc_pkg: shared types and constants for the sensor frame sum checker
// Frame geometry, payload word layouts, verdict codes and register indexes.
// ============================================================================
package sfsc_pkg;

    localparam int FRAME_LEN      = 24;
    localparam int PAYLOAD_OFFSET = 4;
    localparam int PAYLOAD_LEN    = 14;

    localparam int POS_W     = 5;
    localparam int SUM_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int OUT_IDX_W = 4;
    localparam int PIDX_W    = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] SUM_HI_POS = POS_W'(FRAME_LEN - 2);

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET  = 8'h42;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET = 8'h4D;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;

    typedef enum logic [1:0] {
        STATUS_GOOD       = 2'd0,
        STATUS_BAD_HEADER = 2'd1,
        STATUS_BAD_SUM    = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_start;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    payload_byte;
        logic [OUT_IDX_W-1:0] payload_index;
        logic [1:0]           frame_status;
        logic                 last_of_run;
    } out_word_t;

    typedef struct packed {
        logic          valid;
        frame_status_t status;
    } verdict_t;

    typedef logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] payload_row_t;

endpackage

// ===== hw/rtl/sfsc_parser.sv =====
// ============================================================================
// sfsc_parser: frame position tracking, header check and checksum
// Walks each incoming byte through the frame, keeps the running sum and the
// payload bytes, and issues a verdict on the final byte of every frame.
// ============================================================================
module sfsc_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sfsc_pkg::in_word_t                  s_data,
    input  logic                                cfg_valid,
    input  logic [sfsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfsc_pkg::BYTE_W-1:0]         cfg_data,
    input  logic                                emit_busy,
    output sfsc_pkg::verdict_t                  verdict,
    output sfsc_pkg::payload_row_t              payload_snapshot
);
    import sfsc_pkg::*;

    logic [BYTE_W-1:0] header_first_reg, header_first_next;
    logic [BYTE_W-1:0] header_second_reg, header_second_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0] sum_high_reg, sum_high_next;
    logic              hdr_err_reg, hdr_err_next;
    payload_row_t      payload_store_reg, payload_store_next;

    logic              accept;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] rx;
    logic              final_byte;
    logic [SUM_W-1:0]  sum_base;
    logic [SUM_W-1:0]  received_sum;

    // A verdict can only be taken when the emitter has drained the previous one.
    assign s_ready = !(emit_busy && (pos_reg == LAST_POS));
    assign accept  = s_valid && s_ready;

    assign rx           = s_data.rx_byte;
    assign pos          = s_data.frame_start ? '0 : pos_reg;
    assign final_byte   = (pos == LAST_POS);
    assign sum_base     = (pos == '0) ? '0 : sum_reg;
    assign received_sum = {sum_high_reg, rx};

    always_comb begin
        header_first_next  = header_first_reg;
        header_second_next = header_second_reg;
        if (cfg_valid && (cfg_index == CFG_HEADER_FIRST)) begin
            header_first_next = cfg_data;
        end
        if (cfg_valid && (cfg_index == CFG_HEADER_SECOND)) begin
            header_second_next = cfg_data;
        end
    end

    always_comb begin
        pos_next           = pos_reg;
        sum_next           = sum_reg;
        sum_high_next      = sum_high_reg;
        hdr_err_next       = hdr_err_reg;
        payload_store_next = payload_store_reg;
        if (accept) begin
            pos_next = final_byte ? '0 : pos + POS_W'(1);
            if (pos < SUM_HI_POS) begin
                sum_next = sum_base + SUM_W'(rx);
            end
            if (pos == SUM_HI_POS) begin
                sum_high_next = rx;
            end
            if (pos == '0) begin
                hdr_err_next = (rx != header_first_reg);
            end else if (pos == POS_W'(1)) begin
                hdr_err_next = hdr_err_reg || (rx != header_second_reg);
            end
            for (int i = 0; i < PAYLOAD_LEN; i++) begin
                if (pos == POS_W'(PAYLOAD_OFFSET + i)) begin
                    payload_store_next[i] = rx;
                end
            end
        end
    end

    always_comb begin
        verdict.valid  = accept && final_byte;
        verdict.status = STATUS_GOOD;
        priority if (hdr_err_reg) begin
            verdict.status = STATUS_BAD_HEADER;
        end else if (received_sum != sum_reg) begin
            verdict.status = STATUS_BAD_SUM;
        end
    end

    assign payload_snapshot = payload_store_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= HEADER_FIRST_RESET;
            header_second_reg <= HEADER_SECOND_RESET;
            pos_reg           <= '0;
            sum_reg           <= '0;
            sum_high_reg      <= '0;
            hdr_err_reg       <= 1'b0;
        end else begin
            header_first_reg  <= header_first_next;
            header_second_reg <= header_second_next;
            pos_reg           <= pos_next;
            sum_reg           <= sum_next;
            sum_high_reg      <= sum_high_next;
            hdr_err_reg       <= hdr_err_next;
        end
    end

    always_ff @(posedge aclk) begin
        payload_store_reg <= payload_store_next;
    end

    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < POS_W'(FRAME_LEN))
        else $error("frame position beyond frame length");

    a_wrap_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        verdict.valid |=> (pos_reg == '0))
        else $error("position did not wrap after final byte");

    a_no_verdict_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_busy |-> !verdict.valid)
        else $error("verdict issued while emitter busy");

endmodule

// ===== hw/rtl/sfsc_emitter.sv =====
// ============================================================================
// sfsc_emitter: verdict buffer and result word serializer
// Holds the latest verdict and payload copy and sends its result words
// through the output register, one word per cycle while m_ready is high.
// ============================================================================
module sfsc_emitter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sfsc_pkg::verdict_t         verdict,
    input  sfsc_pkg::payload_row_t     payload_snapshot,
    output logic                       emit_busy,
    output logic                       m_valid,
    input  logic                       m_ready,
    output sfsc_pkg::out_word_t        m_data
);
    import sfsc_pkg::*;

    logic                pend_reg, pend_next;
    logic [PIDX_W-1:0]   idx_reg, idx_next;
    frame_status_t       status_reg, status_next;
    payload_row_t        buf_reg;
    logic                m_valid_reg, m_valid_next;
    out_word_t           m_data_reg, m_data_next;

    logic                out_load;
    logic                good;
    logic                last;
    logic [PIDX_W+OUT_IDX_W-1:0] idx_ext;

    assign out_load = pend_reg && (!m_valid_reg || m_ready);
    assign good     = (status_reg == STATUS_GOOD);
    assign last     = !good || (idx_reg == PIDX_W'(PAYLOAD_LEN - 1));
    assign idx_ext  = {{OUT_IDX_W{1'b0}}, idx_reg};

    always_comb begin
        m_data_next = m_data_reg;
        if (out_load) begin
            m_data_next.payload_byte  = good ? buf_reg[idx_reg] : '0;
            m_data_next.payload_index = good ? idx_ext[OUT_IDX_W-1:0] : '0;
            m_data_next.frame_status  = status_reg;
            m_data_next.last_of_run   = last;
        end
    end

    always_comb begin
        pend_next    = pend_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (verdict.valid) begin
            pend_next   = 1'b1;
            idx_next    = '0;
            status_next = verdict.status;
        end else if (out_load) begin
            pend_next = !last;
            idx_next  = last ? '0 : idx_reg + PIDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            idx_reg     <= '0;
            status_reg  <= STATUS_GOOD;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            idx_reg     <= idx_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (verdict.valid) begin
            buf_reg <= payload_snapshot;
        end
    end

    assign emit_busy = pend_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    a_error_is_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !good) |=> (!pend_reg && m_data.last_of_run))
        else $error("error verdict produced more than one word");

    a_run_ends_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last && !verdict.valid) |=> !pend_reg)
        else $error("run continued after its last word");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (idx_reg < PIDX_W'(PAYLOAD_LEN)))
        else $error("payload index out of range");

endmodule

// ===== hw/rtl/sensor_frame_sum_checker_top.sv =====
// ============================================================================
// sensor_frame_sum_checker_top: sensor response frame checker
// Takes one frame byte per word, checks header and 16-bit sum, and returns
// either one error word or the payload bytes of a good frame.
// ============================================================================
// Accepts one input word per cycle while s_ready is high. The verdict on the
// final frame byte waits in the emitter for the single output register; a
// good frame then yields one payload word per cycle while m_ready is high.
// Input is held off only when a new verdict is due while the previous run
// is still draining. Synchronous active-low reset restores the default
// header values and clears the frame position, sum and output state.
module sensor_frame_sum_checker_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sfsc_pkg::in_word_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sfsc_pkg::out_word_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfsc_pkg::BYTE_W-1:0]     cfg_data
);
    import sfsc_pkg::*;

    verdict_t     verdict;
    payload_row_t payload_snapshot;
    logic         emit_busy;

    assign cfg_ready = 1'b1;

    sfsc_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .emit_busy        (emit_busy),
        .verdict          (verdict),
        .payload_snapshot (payload_snapshot)
    );

    sfsc_emitter u_emitter (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .verdict          (verdict),
        .payload_snapshot (payload_snapshot),
        .emit_busy        (emit_busy),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data)
    );

endmodule
